// ===== src/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and character codes for the shell command tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int CodePointWidth = 21;
  localparam int FifoDepth      = 4;

  localparam logic [7:0] ChBackslash  = 8'h5C;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChApostrophe = 8'h27;
  localparam logic [7:0] ChDquote     = 8'h22;

  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic ResAppend  = 1'b0;
  localparam logic ResPartEnd = 1'b1;

  typedef enum logic [1:0] {
    QuoteNone   = 2'd0,
    QuoteSingle = 2'd1,
    QuoteDouble = 2'd2
  } sct_quote_e;

  typedef struct packed {
    logic valid;
    logic kind;
    logic last;
  } sct_res_t;

endpackage

// ===== src/shell_command_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// shell_command_tokenizer_core
// Splits a command line, one character per transaction, into shell-style
// parts with quote and backslash handling.
// ----------------------------------------------------------------------------
// Takes one character or end-of-command transaction per cycle. Each input
// transaction yields zero, one or two results (append a character, or close
// the current part); tlast marks the final result of an input transaction.
// A character is held in the input register, is decoded against the
// quote, escape and pending-part state, and its results enter a four-entry
// result queue, from whose head they are offered on the output port.
// The single output port sets the rate: one result per cycle while the
// receiver is ready, so an item that gives two results (an escaped
// apostrophe inside double quotes) occupies the port for both, and the
// input stalls only when the queue cannot hold two more results.
module shell_command_tokenizer_core import sct_pkg::*; #(
  parameter int CHAR_WIDTH = 21
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [CHAR_WIDTH-1:0] character, zero padded to bytes
  input  logic [((CHAR_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  // [0] kind
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [CHAR_WIDTH-1:0] out_character, zero padded to bytes
  output logic [((CHAR_WIDTH+7)/8)*8-1:0]   m_axis_tdata_o,
  // [0] result_kind
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);

  localparam int DataW = ((CHAR_WIDTH + 7) / 8) * 8;

  logic                  in_valid_q;
  logic                  in_kind_q;
  logic [CHAR_WIDTH-1:0] in_char_q;
  logic                  adv;
  logic                  room;
  logic                  s_take;

  sct_res_t              res0, res1;
  logic [CHAR_WIDTH-1:0] char0, char1;
  logic [CHAR_WIDTH-1:0] out_char;

  assign adv             = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || adv;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_kind_q <= s_axis_tuser_i;
      in_char_q <= s_axis_tdata_i[CHAR_WIDTH-1:0];
    end
  end

  sct_parse #(
    .CHAR_WIDTH(CHAR_WIDTH)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .kind_i  (in_kind_q),
    .char_i  (in_char_q),
    .res0_o  (res0),
    .char0_o (char0),
    .res1_o  (res1),
    .char1_o (char1)
  );

  sct_res_fifo #(
    .CHAR_WIDTH(CHAR_WIDTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv),
    .res0_i  (res0),
    .char0_i (char0),
    .res1_i  (res1),
    .char1_i (char1),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .kind_o  (m_axis_tuser_o),
    .last_o  (m_axis_tlast_o),
    .char_o  (out_char)
  );

  assign m_axis_tdata_o = DataW'(out_char);

endmodule

// ===== src/sct_parse.sv =====
// ----------------------------------------------------------------------------
// sct_parse
// Tokenizer state and per-character decode; produces up to two results.
// ----------------------------------------------------------------------------
module sct_parse import sct_pkg::*; #(
  parameter int CHAR_WIDTH = 21
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  kind_i,
  input  logic [CHAR_WIDTH-1:0] char_i,
  output sct_res_t              res0_o,
  output logic [CHAR_WIDTH-1:0] char0_o,
  output sct_res_t              res1_o,
  output logic [CHAR_WIDTH-1:0] char1_o
);

  localparam int KeepW = (CHAR_WIDTH < CodePointWidth) ? CHAR_WIDTH : CodePointWidth;
  localparam logic [CHAR_WIDTH-1:0] CodeMask = {CHAR_WIDTH{1'b1}} >> (CHAR_WIDTH - KeepW);

  localparam logic [CHAR_WIDTH-1:0] CBackslash  = CHAR_WIDTH'(ChBackslash);
  localparam logic [CHAR_WIDTH-1:0] CSpace      = CHAR_WIDTH'(ChSpace);
  localparam logic [CHAR_WIDTH-1:0] CApostrophe = CHAR_WIDTH'(ChApostrophe);
  localparam logic [CHAR_WIDTH-1:0] CDquote     = CHAR_WIDTH'(ChDquote);

  sct_quote_e quote_q, quote_d;
  logic       esc_q, esc_d;
  logic       part_q, part_d;

  logic [CHAR_WIDTH-1:0] ch_masked;
  logic                  is_apos;
  logic                  bs_emit;
  logic                  esc_left;
  sct_quote_e            code;

  assign ch_masked = char_i & CodeMask;
  assign is_apos   = (char_i == CApostrophe);
  assign code      = is_apos ? QuoteSingle : QuoteDouble;
  assign bs_emit   = esc_q && is_apos;
  assign esc_left  = esc_q && !is_apos;

  always_comb begin
    quote_d = quote_q;
    esc_d   = esc_q;
    part_d  = part_q;
    res0_o  = '0;
    res1_o  = '0;
    char0_o = '0;
    char1_o = '0;
    if (kind_i == KindEnd) begin
      if (part_q) begin
        res0_o.valid = 1'b1;
        res0_o.kind  = ResPartEnd;
      end
      quote_d = QuoteNone;
      esc_d   = 1'b0;
      part_d  = 1'b0;
    end else if (char_i == CBackslash) begin
      if (esc_q || quote_q == QuoteSingle) begin
        res0_o.valid = 1'b1;
        res0_o.kind  = ResAppend;
        char0_o      = ch_masked;
        esc_d        = 1'b0;
      end else begin
        esc_d = 1'b1;
      end
    end else if (char_i == CSpace) begin
      if (quote_q != QuoteNone) begin
        res0_o.valid = 1'b1;
        res0_o.kind  = ResAppend;
        char0_o      = ch_masked;
      end else if (part_q) begin
        res0_o.valid = 1'b1;
        res0_o.kind  = ResPartEnd;
        part_d       = 1'b0;
      end
      esc_d = 1'b0;
    end else if (is_apos || char_i == CDquote) begin
      if (bs_emit) begin
        res0_o.valid = 1'b1;
        res0_o.kind  = ResAppend;
        char0_o      = CBackslash & CodeMask;
      end
      if (!esc_left) begin
        if (quote_q == code) begin
          quote_d = QuoteNone;
        end else if (quote_q != QuoteNone) begin
          if (bs_emit) begin
            res1_o.valid = 1'b1;
            res1_o.kind  = ResAppend;
            char1_o      = ch_masked;
          end else begin
            res0_o.valid = 1'b1;
            res0_o.kind  = ResAppend;
            char0_o      = ch_masked;
          end
        end else begin
          quote_d = code;
        end
      end else begin
        res0_o.valid = 1'b1;
        res0_o.kind  = ResAppend;
        char0_o      = ch_masked;
      end
      esc_d = 1'b0;
    end else begin
      res0_o.valid = 1'b1;
      res0_o.kind  = ResAppend;
      char0_o      = ch_masked;
      part_d       = 1'b1;
      esc_d        = 1'b0;
    end
    res1_o.last = res1_o.valid;
    res0_o.last = res0_o.valid && !res1_o.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q <= QuoteNone;
      esc_q   <= 1'b0;
      part_q  <= 1'b0;
    end else if (adv_i) begin
      quote_q <= quote_d;
      esc_q   <= esc_d;
      part_q  <= part_d;
    end
  end

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res1_o.valid |-> res0_o.valid)
    else $error("second result without first");

  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res0_o.valid || res1_o.valid) |-> $onehot({res0_o.last, res1_o.last}))
    else $error("last flag not unique");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && kind_i == KindEnd) |=> (quote_q == QuoteNone && !esc_q && !part_q))
    else $error("end of command did not clear state");

endmodule

// ===== src/sct_res_fifo.sv =====
// ----------------------------------------------------------------------------
// sct_res_fifo
// Small result queue; takes up to two results a cycle, emits one.
// ----------------------------------------------------------------------------
module sct_res_fifo import sct_pkg::*; #(
  parameter int CHAR_WIDTH = 21
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sct_res_t              res0_i,
  input  logic [CHAR_WIDTH-1:0] char0_i,
  input  sct_res_t              res1_i,
  input  logic [CHAR_WIDTH-1:0] char1_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic                  kind_o,
  output logic                  last_o,
  output logic [CHAR_WIDTH-1:0] char_o
);

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  logic [CHAR_WIDTH-1:0] char_q [FifoDepth];
  logic                  kind_q [FifoDepth];
  logic                  last_q [FifoDepth];

  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic [PtrW-1:0] wr_next;
  logic            pop;
  logic            push0, push1;
  logic [CntW-1:0] n_push;

  assign pop     = valid_o && ready_i;
  assign push0   = push_i && res0_i.valid;
  assign push1   = push_i && res1_i.valid;
  assign n_push  = CntW'(push0) + CntW'(push1);
  assign wr_next = wr_q + PtrW'(1);
  assign room_o  = (cnt_q <= CntW'(FifoDepth - 2));
  assign valid_o = (cnt_q != '0);
  assign kind_o  = kind_q[rd_q];
  assign last_o  = last_q[rd_q];
  assign char_o  = char_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push0) begin
      char_q[wr_q] <= char0_i;
      kind_q[wr_q] <= res0_i.kind;
      last_q[wr_q] <= res0_i.last;
    end
    if (push1) begin
      char_q[wr_next] <= char1_i;
      kind_q[wr_next] <= res1_i.kind;
      last_q[wr_next] <= res1_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(n_push);
      if (pop) begin
        rd_q <= rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + n_push - CntW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("push without room");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && n_push == '0) |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("pop did not reduce count");

endmodule
